/* src/boiler_plant_lfsr_model_core_macros.svh */
// Assertion macros for the boiler plant LFSR model core.
// Each macro expects clk and rst_n to be in scope where it is used.
`ifndef BOILER_PLANT_LFSR_MODEL_CORE_MACROS_SVH
`define BOILER_PLANT_LFSR_MODEL_CORE_MACROS_SVH

// check a condition at every clock edge outside reset
`define BPLM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// check a consequence in the same cycle as its antecedent
`define BPLM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check a consequence in the cycle after its antecedent
`define BPLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bplm_pkg.sv */
// Shared types, constants and LFSR helper for the boiler plant LFSR model core.
// No dependencies; used by bplm_tick and boiler_plant_lfsr_model_core.
package bplm_pkg;

  localparam int unsigned NOISE_W   = 16;
  localparam int unsigned LEVEL_W   = 32;
  localparam int unsigned STEP_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned DRAWS     = 3;

  localparam logic [NOISE_W-1:0] NOISE_SEED     = 16'h0001;
  localparam logic [LEVEL_W-1:0] PRESSURE_VENT  = 32'h0000_0100;
  localparam logic [LEVEL_W-1:0] TEMP_RESET     = 32'h0000_0000;
  localparam logic [STEP_W-1:0]  PUMP_STEP_RST  = 16'd16;
  localparam logic [STEP_W-1:0]  FLOW_STEP_RST  = 16'd8;
  localparam logic [STEP_W-1:0]  HEAT_STEP_RST  = 16'd4;
  localparam logic [STEP_W-1:0]  LOSS_STEP_RST  = 16'd1;
  localparam logic [LEVEL_W-1:0] AMBIENT_RST    = 32'd20;

  localparam logic [1:0] MODE_VENT = 2'd0;
  localparam logic [1:0] MODE_OPEN = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_PUMP_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOW_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AMBIENT   = 3'd4;

  typedef struct packed {
    logic [1:0] valve_mode;
    logic       pump_on;
    logic       heater_on;
  } in_req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] temperature_now;
    logic [LEVEL_W-1:0] pressure_now;
  } out_req_t;

  typedef struct packed {
    logic [STEP_W-1:0]  pump_step;
    logic [STEP_W-1:0]  flow_step;
    logic [STEP_W-1:0]  heat_step;
    logic [STEP_W-1:0]  loss_step;
    logic [LEVEL_W-1:0] ambient_level;
  } cfg_t;

  typedef struct packed {
    logic [NOISE_W-1:0] noise;
    logic [LEVEL_W-1:0] pressure;
    logic [LEVEL_W-1:0] temperature;
  } plant_state_t;

  function automatic logic lfsr_bit(input logic [NOISE_W-1:0] r);
    lfsr_bit = r[0] ^ r[2] ^ r[3] ^ r[5];
  endfunction

endpackage

/* src/boiler_plant_lfsr_model_core.sv */
// Boiler plant tick model: LFSR-driven pressure and temperature, one result
// per request. Depends on bplm_pkg, bplm_tick and the core macros header.
//
//   channel | direction | handshake            | payload
//   in_     | request   | in_valid / in_ready  | in_data  (bplm_pkg::in_req_t)
//   out_    | result    | out_valid / out_ready| out_data (bplm_pkg::out_req_t)
//   cfg_    | write     | cfg_we               | cfg_index, cfg_wdata
//
// One request per cycle while not stalled; its result is valid in the next cycle.
// Throughput is set by the single output register, refilled in the cycle it drains.
// Synchronous active-low reset loads the seed, vent pressure and register defaults.
// in_ready drops only while a result is held and out_ready is low.
`include "boiler_plant_lfsr_model_core_macros.svh"

module boiler_plant_lfsr_model_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bplm_pkg::in_req_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bplm_pkg::out_req_t                  out_data,
  input  logic                                cfg_we,
  input  logic [bplm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bplm_pkg::CFG_DAT_W-1:0]      cfg_wdata
);

  bplm_pkg::cfg_t         cfg_r;
  bplm_pkg::plant_state_t state_r;
  bplm_pkg::plant_state_t state_nxt;
  bplm_pkg::out_req_t     out_data_r;
  logic                   out_valid_r;
  logic                   in_accept;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  bplm_tick u_tick (
    .cur (state_r),
    .cfg (cfg_r),
    .req (in_data),
    .nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pump_step     <= bplm_pkg::PUMP_STEP_RST;
      cfg_r.flow_step     <= bplm_pkg::FLOW_STEP_RST;
      cfg_r.heat_step     <= bplm_pkg::HEAT_STEP_RST;
      cfg_r.loss_step     <= bplm_pkg::LOSS_STEP_RST;
      cfg_r.ambient_level <= bplm_pkg::AMBIENT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bplm_pkg::REG_PUMP_STEP: cfg_r.pump_step     <= cfg_wdata[bplm_pkg::STEP_W-1:0];
        bplm_pkg::REG_FLOW_STEP: cfg_r.flow_step     <= cfg_wdata[bplm_pkg::STEP_W-1:0];
        bplm_pkg::REG_HEAT_STEP: cfg_r.heat_step     <= cfg_wdata[bplm_pkg::STEP_W-1:0];
        bplm_pkg::REG_LOSS_STEP: cfg_r.loss_step     <= cfg_wdata[bplm_pkg::STEP_W-1:0];
        bplm_pkg::REG_AMBIENT:   cfg_r.ambient_level <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.noise       <= bplm_pkg::NOISE_SEED;
      state_r.pressure    <= bplm_pkg::PRESSURE_VENT;
      state_r.temperature <= bplm_pkg::TEMP_RESET;
      out_valid_r         <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r.temperature_now <= state_nxt.temperature;
      out_data_r.pressure_now    <= state_nxt.pressure;
    end
  end

  `BPLM_ASSERT_ALWAYS(a_noise_nonzero, state_r.noise != '0, "noise register reached zero")
  `BPLM_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid_r, "request produced no result")
  `BPLM_ASSERT_NEXT(a_result_matches_state, in_accept, out_data_r.pressure_now == state_r.pressure && out_data_r.temperature_now == state_r.temperature, "result differs from plant state")
  `BPLM_ASSERT_NEXT(a_state_holds_idle, !in_accept, $stable(state_r), "plant state moved without a request")

endmodule

/* src/bplm_tick.sv */
// Next-state logic for one plant tick: up to three LFSR draws, pressure and
// temperature updates. Depends on bplm_pkg.
module bplm_tick (
  input  bplm_pkg::plant_state_t cur,
  input  bplm_pkg::cfg_t         cfg,
  input  bplm_pkg::in_req_t      req,
  output bplm_pkg::plant_state_t nxt
);

  logic [bplm_pkg::NOISE_W-1:0] lf [bplm_pkg::DRAWS+1];
  logic [bplm_pkg::DRAWS-1:0]   fb;
  logic                         pump_draw;
  logic                         flow_draw;
  logic                         temp_draw;
  logic [1:0]                   temp_idx;
  logic [1:0]                   total;
  logic                         pump_bit;
  logic                         flow_bit;
  logic                         temp_bit;
  logic [bplm_pkg::LEVEL_W-1:0] p_pump;
  logic [bplm_pkg::LEVEL_W-1:0] p_flow;

  always_comb begin
    lf[0] = cur.noise;
    for (int i = 0; i < bplm_pkg::DRAWS; i++) begin
      fb[i]   = bplm_pkg::lfsr_bit(lf[i]);
      lf[i+1] = {fb[i], lf[i][bplm_pkg::NOISE_W-1:1]};
    end
  end

  always_comb begin
    pump_draw = (req.valve_mode != bplm_pkg::MODE_VENT) && req.pump_on;
    flow_draw = (req.valve_mode == bplm_pkg::MODE_OPEN);
    temp_draw = req.heater_on || (cur.temperature > cfg.ambient_level);
    temp_idx  = {1'b0, pump_draw} + {1'b0, flow_draw};
    total     = temp_idx + {1'b0, temp_draw};

    pump_bit = pump_draw && fb[0];
    flow_bit = flow_draw && (pump_draw ? fb[1] : fb[0]);
    case (temp_idx)
      2'd0:    temp_bit = fb[0];
      2'd1:    temp_bit = fb[1];
      2'd2:    temp_bit = fb[2];
      default: temp_bit = 1'b0;
    endcase
    temp_bit = temp_bit && temp_draw;

    p_pump = cur.pressure + (pump_bit ? {16'h0000, cfg.pump_step} : '0);
    p_flow = p_pump - (flow_bit ? {16'h0000, cfg.flow_step} : '0);

    nxt.pressure = (req.valve_mode == bplm_pkg::MODE_VENT) ? bplm_pkg::PRESSURE_VENT
                                                            : p_flow;

    if (!temp_bit) begin
      nxt.temperature = cur.temperature;
    end else if (req.heater_on) begin
      nxt.temperature = cur.temperature + {16'h0000, cfg.heat_step};
    end else begin
      nxt.temperature = cur.temperature - {16'h0000, cfg.loss_step};
    end

    case (total)
      2'd0:    nxt.noise = lf[0];
      2'd1:    nxt.noise = lf[1];
      2'd2:    nxt.noise = lf[2];
      default: nxt.noise = lf[3];
    endcase
  end

endmodule

/* tb/sv/boiler_plant_lfsr_model_core_tb.sv */
// Self-checking testbench for boiler_plant_lfsr_model_core: drives tick requests,
// register writes and random backpressure, and checks every result against a
// tracker of the plant state. Depends on bplm_pkg and the core RTL only.
module boiler_plant_lfsr_model_core_tb;

  localparam logic [1:0] VALVE_CLOSED = 2'd2;
  localparam logic [1:0] VALVE_SPARE  = 2'd3;
  localparam logic [1:0] VALVE_CODES [4] = '{bplm_pkg::MODE_VENT, bplm_pkg::MODE_OPEN,
                                             VALVE_CLOSED, VALVE_SPARE};

  localparam logic [bplm_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;
  localparam logic [bplm_pkg::CFG_IDX_W-1:0] REG_UNUSED_LAST  = 3'd7;

  localparam int unsigned PHASES          = 8;
  localparam int unsigned TICKS_PER_PHASE = 180;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT     = 600000;

  class boiler_tracker;
    bplm_pkg::cfg_t         settings;
    bplm_pkg::plant_state_t plant;
    bplm_pkg::out_req_t     expected_levels [$];
    int unsigned            mismatches;
    int unsigned            checked;
    int unsigned            cooling_ticks;
    int unsigned            valve_ticks [4];

    function new();
      settings = '{pump_step: bplm_pkg::PUMP_STEP_RST, flow_step: bplm_pkg::FLOW_STEP_RST,
                   heat_step: bplm_pkg::HEAT_STEP_RST, loss_step: bplm_pkg::LOSS_STEP_RST,
                   ambient_level: bplm_pkg::AMBIENT_RST};
      plant = '{noise: bplm_pkg::NOISE_SEED, pressure: bplm_pkg::PRESSURE_VENT,
                temperature: bplm_pkg::TEMP_RESET};
      mismatches = 0;
      checked = 0;
      cooling_ticks = 0;
      valve_ticks = '{0, 0, 0, 0};
    endfunction

    function void set_register(logic [bplm_pkg::CFG_IDX_W-1:0] idx,
                               logic [bplm_pkg::CFG_DAT_W-1:0] data);
      case (idx)
        bplm_pkg::REG_PUMP_STEP: settings.pump_step = data[bplm_pkg::STEP_W-1:0];
        bplm_pkg::REG_FLOW_STEP: settings.flow_step = data[bplm_pkg::STEP_W-1:0];
        bplm_pkg::REG_HEAT_STEP: settings.heat_step = data[bplm_pkg::STEP_W-1:0];
        bplm_pkg::REG_LOSS_STEP: settings.loss_step = data[bplm_pkg::STEP_W-1:0];
        bplm_pkg::REG_AMBIENT:   settings.ambient_level = data[bplm_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    function bit next_noise_bit();
      bit fb;
      fb = plant.noise[0] ^ plant.noise[2] ^ plant.noise[3] ^ plant.noise[5];
      plant.noise = {fb, plant.noise[bplm_pkg::NOISE_W-1:1]};
      return fb;
    endfunction

    function void note_tick(bplm_pkg::in_req_t tick);
      bplm_pkg::out_req_t levels;
      valve_ticks[tick.valve_mode]++;
      if (tick.valve_mode == bplm_pkg::MODE_VENT) begin
        plant.pressure = bplm_pkg::PRESSURE_VENT;
      end else begin
        if (tick.pump_on) begin
          if (next_noise_bit())
            plant.pressure = plant.pressure + {16'h0000, settings.pump_step};
        end
        if (tick.valve_mode == bplm_pkg::MODE_OPEN) begin
          if (next_noise_bit())
            plant.pressure = plant.pressure - {16'h0000, settings.flow_step};
        end
      end
      if (tick.heater_on) begin
        if (next_noise_bit())
          plant.temperature = plant.temperature + {16'h0000, settings.heat_step};
      end else if (plant.temperature > settings.ambient_level) begin
        cooling_ticks++;
        if (next_noise_bit())
          plant.temperature = plant.temperature - {16'h0000, settings.loss_step};
      end
      levels.temperature_now = plant.temperature;
      levels.pressure_now = plant.pressure;
      expected_levels.push_back(levels);
    endfunction

    function void check_levels(bplm_pkg::out_req_t got);
      bplm_pkg::out_req_t want;
      if (expected_levels.size() == 0) begin
        mismatches++;
        $error("result with no request outstanding: temperature_now %0d, pressure_now %0d",
               got.temperature_now, got.pressure_now);
        return;
      end
      want = expected_levels.pop_front();
      checked++;
      if (got.temperature_now !== want.temperature_now) begin
        mismatches++;
        $error("temperature_now: expected %0d, actual %0d",
               want.temperature_now, got.temperature_now);
      end
      if (got.pressure_now !== want.pressure_now) begin
        mismatches++;
        $error("pressure_now: expected %0d, actual %0d", want.pressure_now, got.pressure_now);
      end
    endfunction

    function int unsigned pending();
      return expected_levels.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  bplm_pkg::in_req_t               in_data;
  logic                            out_valid;
  logic                            out_ready;
  bplm_pkg::out_req_t              out_data;
  logic                            cfg_we;
  logic [bplm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bplm_pkg::CFG_DAT_W-1:0]  cfg_wdata;

  boiler_tracker sb;
  bit            tx_calm;
  bit            rx_calm;
  int unsigned   rx_hold_req;
  int unsigned   cycle_count;
  int unsigned   reg_writes;
  int unsigned   settings_run;

  boiler_plant_lfsr_model_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_register(cfg_index, cfg_wdata);
      if (in_valid && in_ready) sb.note_tick(in_data);
      if (out_valid && out_ready) sb.check_levels(out_data);
    end
  end

  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req != 0) begin
        stall_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (rx_calm || $urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left = idle_span() - 1;
      end
    end
  end

  task automatic send_tick(input bplm_pkg::in_req_t tick);
    int unsigned gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= tick;
    do @(posedge clk); while (!in_ready);
    gap = (tx_calm || $urandom_range(0, 99) < 65) ? 0 : idle_span();
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_plant();
    if (in_valid) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bplm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bplm_pkg::CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  function automatic logic [bplm_pkg::STEP_W-1:0] random_step();
    if ($urandom_range(0, 9) == 0) return bplm_pkg::STEP_W'($urandom());
    return bplm_pkg::STEP_W'($urandom_range(0, 300));
  endfunction

  // write all registers for one phase; upper bits of the narrow ones carry junk
  task automatic configure(input int unsigned phase);
    logic [bplm_pkg::STEP_W-1:0]  pump, flow, heat, loss;
    logic [bplm_pkg::LEVEL_W-1:0] amb;
    case (phase)
      0: begin
        pump = bplm_pkg::PUMP_STEP_RST; flow = bplm_pkg::FLOW_STEP_RST;
        heat = bplm_pkg::HEAT_STEP_RST; loss = bplm_pkg::LOSS_STEP_RST;
        amb = bplm_pkg::AMBIENT_RST;
      end
      1: begin
        pump = '0; flow = '0; heat = '0; loss = '0; amb = '0;
      end
      2: begin
        pump = '1; flow = '1; heat = '1; loss = '1; amb = '1;
      end
      3: begin
        pump = '1; flow = '1; heat = '1; loss = '1; amb = '0;
      end
      default: begin
        pump = random_step(); flow = random_step();
        heat = random_step(); loss = random_step();
        amb = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 3000);
      end
    endcase
    for (int i = REG_UNUSED_FIRST; i <= REG_UNUSED_LAST; i++)
      write_reg(bplm_pkg::CFG_IDX_W'(i), $urandom());
    write_reg(bplm_pkg::REG_PUMP_STEP, {16'($urandom()), pump});
    write_reg(bplm_pkg::REG_FLOW_STEP, {16'($urandom()), flow});
    write_reg(bplm_pkg::REG_HEAT_STEP, {16'($urandom()), heat});
    write_reg(bplm_pkg::REG_LOSS_STEP, {16'($urandom()), loss});
    write_reg(bplm_pkg::REG_AMBIENT, amb);
    settings_run++;
  endtask

  function automatic bplm_pkg::in_req_t random_tick(input int unsigned heat_pct);
    bplm_pkg::in_req_t t;
    int unsigned       r;
    r = $urandom_range(0, 99);
    if (r < 15) t.valve_mode = bplm_pkg::MODE_VENT;
    else if (r < 55) t.valve_mode = bplm_pkg::MODE_OPEN;
    else if (r < 85) t.valve_mode = VALVE_CLOSED;
    else t.valve_mode = VALVE_SPARE;
    t.pump_on = ($urandom_range(0, 99) < 60);
    t.heater_on = ($urandom_range(0, 99) < heat_pct);
    return t;
  endfunction

  initial begin
    bplm_pkg::in_req_t tick;
    int unsigned       heat_pct;
    int unsigned       failures;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    rx_hold_req = 0;
    reg_writes = 0;
    settings_run = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every valve mode with every pump and heater command, reset settings
    foreach (VALVE_CODES[v]) begin
      for (int p = 0; p < 2; p++) begin
        for (int h = 0; h < 2; h++) begin
          tick = '{valve_mode: VALVE_CODES[v], pump_on: p[0], heater_on: h[0]};
          send_tick(tick);
        end
      end
    end

    // heat past a zero ambient, then cool with the largest loss to wrap below zero
    drain_plant();
    write_reg(bplm_pkg::REG_HEAT_STEP, '1);
    write_reg(bplm_pkg::REG_LOSS_STEP, '1);
    write_reg(bplm_pkg::REG_AMBIENT, '0);
    settings_run++;
    for (int i = 0; i < 5; i++) begin
      tick = '{valve_mode: VALVE_CLOSED, pump_on: 1'b0, heater_on: (i < 2)};
      send_tick(tick);
    end

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      drain_plant();
      configure(phase);
      tx_calm = (phase == 6);
      rx_calm = (phase == 6);
      heat_pct = $urandom_range(25, 75);
      for (int unsigned n = 0; n < TICKS_PER_PHASE; n++) begin
        if (phase == 2 && n == 40) rx_hold_req = HOLD_OFF_CYCLES;
        if (phase == 5 && n == 90) drain_plant();
        send_tick(random_tick(heat_pct));
      end
    end

    drain_plant();
    repeat (4) @(posedge clk);
    failures = sb.mismatches + sb.pending();
    $display("Checked %0d ticks (vent %0d, open %0d, closed %0d, unused mode %0d) over %0d settings",
             sb.checked, sb.valve_ticks[bplm_pkg::MODE_VENT],
             sb.valve_ticks[bplm_pkg::MODE_OPEN], sb.valve_ticks[VALVE_CLOSED],
             sb.valve_ticks[VALVE_SPARE], settings_run);
    $display("%0d ticks took the cooling path, %0d register writes, %0d mismatches",
             sb.cooling_ticks, reg_writes, sb.mismatches);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/bplm_pkg.sv
src/bplm_tick.sv
src/boiler_plant_lfsr_model_core.sv
tb/sv/boiler_plant_lfsr_model_core_tb.sv
